### rtl/core/pfp_pkg.sv
// Shared types and constants of the page framebuffer plotter.
`timescale 1ns / 1ps

package pfp_pkg;

  // Input command codes.
  localparam logic [1:0] CMD_PLOT    = 2'd0;
  localparam logic [1:0] CMD_CLEAR   = 2'd1;
  localparam logic [1:0] CMD_REFRESH = 2'd2;

  // Panel command bytes at the head of each page.
  localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
  localparam logic [7:0] COL_LOW_CMD   = 8'h00;
  localparam logic [7:0] COL_HIGH_CMD  = 8'h10;

  // Operations handed from the front end to the back end.
  typedef enum logic [1:0] {
    OP_PLOT  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_EMIT  = 2'd2,
    OP_READ  = 2'd3
  } op_kind_e;

  // Operation bits beside the store address: kind, data byte and one flag.
  localparam int unsigned OP_FIXED_W = $bits(op_kind_e) + 8 + 1;

  // One result item.
  typedef struct packed {
    logic [7:0] byte_out;
    logic       is_data;
    logic       frame_end;
  } result_t;

endpackage

### rtl/core/pfp_fifo.sv
// Small first-in first-out queue built from registers.
`timescale 1ns / 1ps

module pfp_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  logic [Width-1:0] entry_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign rdata_o = entry_q[rptr_q];

  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  // Pointer and fill count update.
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= wdata_i;
    end
  end

endmodule

### rtl/core/pfp_front.sv
// Front end: takes input items, tracks the refresh stream and issues store operations.
`timescale 1ns / 1ps

module pfp_front
  import pfp_pkg::*;
#(
  parameter int unsigned COLUMNS = 128,
  parameter int unsigned PAGES   = 8,
  parameter int unsigned AddrW   = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic                        full_i,
  input  logic [1:0]                  command_i,
  input  logic [7:0]                  x_pos_i,
  input  logic [7:0]                  y_pos_i,
  input  logic                        fill_i,
  output logic                        op_push_o,
  output logic [AddrW+OP_FIXED_W-1:0] op_o
);

  localparam int unsigned PageW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned ColW  = $clog2(COLUMNS);
  localparam int unsigned SlotW = $clog2(COLUMNS + 3);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(COLUMNS + 2);
  localparam logic [PageW-1:0] LastPage = PageW'(PAGES - 1);
  localparam logic [8:0]       MaxX     = 9'(COLUMNS - 1);
  localparam logic [8:0]       MaxY     = 9'(8 * PAGES - 1);

  typedef struct packed {
    op_kind_e         kind;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
    logic             flag;
  } op_t;

  logic [PageW-1:0] page_q, page_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic             accept;
  logic             on_panel;
  logic [PageW-1:0] plot_page;
  logic [ColW-1:0]  plot_col;
  logic [SlotW-1:0] slot_col;
  logic [ColW-1:0]  read_col;
  op_t              op;

  assign accept   = push_i & ~full_i;
  assign on_panel = ({1'b0, x_pos_i} <= MaxX) && ({1'b0, y_pos_i} <= MaxY);

  // The picture is stored upside down: low rows land in the last page.
  assign plot_page = LastPage - PageW'(y_pos_i[7:3]);
  assign plot_col  = x_pos_i[ColW-1:0];

  // Data bytes follow three command bytes within each page.
  assign slot_col = slot_q - SlotW'(3);
  assign read_col = slot_col[ColW-1:0];

  // Classify the item and build the operation for the back end.
  always_comb begin
    op        = '{kind: OP_PLOT, addr: '0, data: '0, flag: 1'b0};
    op_push_o = 1'b0;
    page_d    = page_q;
    slot_d    = slot_q;
    if (accept) begin
      unique case (command_i)
        CMD_PLOT: begin
          op.kind   = OP_PLOT;
          op.addr   = AddrW'(int'(plot_col) * PAGES + int'(plot_page));
          op.data   = 8'h80 >> y_pos_i[2:0];
          op.flag   = fill_i;
          op_push_o = on_panel;
        end
        CMD_CLEAR: begin
          op.kind   = OP_CLEAR;
          op_push_o = 1'b1;
        end
        CMD_REFRESH: begin
          op_push_o = 1'b1;
          if (slot_q == SlotW'(0)) begin
            op.kind = OP_EMIT;
            op.data = PAGE_CMD_BASE + 8'(page_q);
          end else if (slot_q == SlotW'(1)) begin
            op.kind = OP_EMIT;
            op.data = COL_LOW_CMD;
          end else if (slot_q == SlotW'(2)) begin
            op.kind = OP_EMIT;
            op.data = COL_HIGH_CMD;
          end else begin
            op.kind = OP_READ;
            op.addr = AddrW'(int'(read_col) * PAGES + int'(page_q));
            op.flag = (page_q == LastPage) && (slot_q == LastSlot);
          end
          // Step through the stream and wrap after the last page.
          if (slot_q == LastSlot) begin
            slot_d = '0;
            page_d = (page_q == LastPage) ? '0 : page_q + 1'b1;
          end else begin
            slot_d = slot_q + 1'b1;
          end
        end
        default: begin
          op_push_o = 1'b0;
        end
      endcase
    end
  end

  assign op_o = op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q <= '0;
      slot_q <= '0;
    end else begin
      page_q <= page_d;
      slot_q <= slot_d;
    end
  end

endmodule

### rtl/core/pfp_back.sv
// Back end: owns the frame store and carries out plot, clear and refresh operations.
`timescale 1ns / 1ps

module pfp_back
  import pfp_pkg::*;
#(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        op_empty_i,
  input  logic [AddrW+OP_FIXED_W-1:0] op_i,
  output logic                        op_pop_o,
  input  logic                        out_full_i,
  output logic                        out_push_o,
  output result_t                     out_data_o,
  output logic                        init_busy_o
);

  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  typedef struct packed {
    op_kind_e         kind;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
    logic             flag;
  } op_t;

  typedef enum logic [4:0] {
    ST_INIT  = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_CLEAR = 5'b00100,
    ST_RMW   = 5'b01000,
    ST_READ  = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [AddrW-1:0] cnt_q, cnt_d;
  op_t              head;
  op_t              hold_q, hold_d;
  logic [7:0]       mem_q [Depth];
  logic [7:0]       rdata_q;
  logic             mem_re;
  logic [AddrW-1:0] mem_raddr;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [7:0]       mem_wdata;

  assign head        = op_i;
  assign init_busy_o = (state_q == ST_INIT);

  // Operation sequencer.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    hold_d     = hold_q;
    op_pop_o   = 1'b0;
    out_push_o = 1'b0;
    out_data_o = '{byte_out: '0, is_data: 1'b0, frame_end: 1'b0};
    mem_re     = 1'b0;
    mem_raddr  = head.addr;
    mem_we     = 1'b0;
    mem_waddr  = cnt_q;
    mem_wdata  = '0;
    unique case (state_q) inside
      ST_INIT, ST_CLEAR: begin
        // Zero one store byte per cycle.
        mem_we = 1'b1;
        if (cnt_q == LastAddr) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (!op_empty_i) begin
          unique case (head.kind)
            OP_PLOT: begin
              mem_re   = 1'b1;
              hold_d   = head;
              op_pop_o = 1'b1;
              state_d  = ST_RMW;
            end
            OP_CLEAR: begin
              op_pop_o = 1'b1;
              cnt_d    = '0;
              state_d  = ST_CLEAR;
            end
            OP_EMIT: begin
              if (!out_full_i) begin
                op_pop_o   = 1'b1;
                out_push_o = 1'b1;
                out_data_o = '{byte_out: head.data, is_data: 1'b0, frame_end: 1'b0};
              end
            end
            OP_READ: begin
              if (!out_full_i) begin
                mem_re   = 1'b1;
                hold_d   = head;
                op_pop_o = 1'b1;
                state_d  = ST_READ;
              end
            end
            default: begin
              op_pop_o = 1'b1;
            end
          endcase
        end
      end
      ST_RMW: begin
        // Write back the byte with the one pixel changed.
        mem_we    = 1'b1;
        mem_waddr = hold_q.addr;
        mem_wdata = hold_q.flag ? (rdata_q | hold_q.data) : (rdata_q & ~hold_q.data);
        state_d   = ST_IDLE;
      end
      ST_READ: begin
        out_push_o = 1'b1;
        out_data_o = '{byte_out: rdata_q, is_data: 1'b1, frame_end: hold_q.flag};
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Held operation payload.
  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
  end

  // Frame store with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

`ifndef SYNTHESIS
  // A write-back or read capture always directly follows its issue in idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RMW || state_q == ST_READ) |-> $past(state_q) == ST_IDLE)
    else $error("store access phase not entered from idle");

  // A result is never pushed into a full output queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |-> !out_full_i)
    else $error("result pushed into full output queue");

  // Operations leave the queue only while idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_pop_o |-> (state_q == ST_IDLE && !op_empty_i))
    else $error("operation taken outside idle");

  // The sweep ends by returning to idle with the counter cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_INIT || state_q == ST_CLEAR) && cnt_q == LastAddr)
      |=> (state_q == ST_IDLE && cnt_q == '0))
    else $error("store sweep did not finish cleanly");
`endif

endmodule

### rtl/core/page_framebuffer_plotter.sv
// Top level of the page framebuffer plotter: front end, operation queue, back end, result queue.
//
//   channel   direction  transfer when        payload
//   input     in         push_i & !full_o     command_i, x_pos_i, y_pos_i, fill_i
//   result    out        pop_i & !empty_o     byte_out_o, is_data_o, frame_end_o
//
// The front end classifies an item in the cycle it is taken and queues an operation.
// In the back end a plot is a read-modify-write of one store byte (a store read, then a write-back),
// a refresh data byte is a store read followed by its output, and a refresh command byte goes out from idle.
// A clear sweeps the store, one byte per cycle.
// After reset the same sweep runs with full_o held high.
// Two-entry queues on both sides let input and result traffic stall independently.
`timescale 1ns / 1ps

module page_framebuffer_plotter
  import pfp_pkg::*;
#(
  parameter int unsigned COLUMNS = 128,
  parameter int unsigned PAGES   = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  logic [1:0] command_i,
  input  logic [7:0] x_pos_i,
  input  logic [7:0] y_pos_i,
  input  logic       fill_i,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [7:0] byte_out_o,
  output logic       is_data_o,
  output logic       frame_end_o
);

  localparam int unsigned Depth = COLUMNS * PAGES;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned OpW   = AddrW + OP_FIXED_W;
  localparam int unsigned ResW  = $bits(result_t);

  logic           op_push, op_pop, op_full, op_empty;
  logic [OpW-1:0] op_wdata, op_rdata;
  logic           out_push, out_full;
  result_t        out_wdata, out_rdata;
  logic           init_busy;

  assign full_o = op_full | init_busy;

  // Front end.
  pfp_front #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES),
    .AddrW  (AddrW)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push_i),
    .full_i   (full_o),
    .command_i(command_i),
    .x_pos_i  (x_pos_i),
    .y_pos_i  (y_pos_i),
    .fill_i   (fill_i),
    .op_push_o(op_push),
    .op_o     (op_wdata)
  );

  // Operation queue between front and back end.
  pfp_fifo #(
    .Width(OpW),
    .Depth(2)
  ) u_op_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (op_push),
    .wdata_i(op_wdata),
    .pop_i  (op_pop),
    .rdata_o(op_rdata),
    .full_o (op_full),
    .empty_o(op_empty)
  );

  // Back end with the frame store.
  pfp_back #(
    .Depth(Depth),
    .AddrW(AddrW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_empty_i (op_empty),
    .op_i       (op_rdata),
    .op_pop_o   (op_pop),
    .out_full_i (out_full),
    .out_push_o (out_push),
    .out_data_o (out_wdata),
    .init_busy_o(init_busy)
  );

  // Result queue.
  pfp_fifo #(
    .Width(ResW),
    .Depth(2)
  ) u_out_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .wdata_i(out_wdata),
    .pop_i  (pop_i),
    .rdata_o(out_rdata),
    .full_o (out_full),
    .empty_o(empty_o)
  );

  assign byte_out_o  = out_rdata.byte_out;
  assign is_data_o   = out_rdata.is_data;
  assign frame_end_o = out_rdata.frame_end;

endmodule

### verif/page_framebuffer_plotter_tb.sv
// Self-checking testbench for the page framebuffer plotter: plots, clears and refresh stream.
`timescale 1ns / 1ps

module page_framebuffer_plotter_tb;
  import pfp_pkg::*;

  localparam int unsigned COLUMNS      = 128;
  localparam int unsigned PAGES        = 8;
  localparam int unsigned ROWS         = 8 * PAGES;
  localparam int unsigned PAGE_SPAN    = COLUMNS + 3;
  localparam int unsigned STREAM_LEN   = PAGES * PAGE_SPAN;
  localparam int unsigned STORE_BYTES  = COLUMNS * PAGES;
  localparam int unsigned IDLE_PCT     = 9;
  localparam int unsigned DRAIN_CYCLES = STORE_BYTES + 64;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       push_i      = 1'b0;
  logic [1:0] command_i   = CMD_PLOT;
  logic [7:0] x_pos_i     = '0;
  logic [7:0] y_pos_i     = '0;
  logic       fill_i      = 1'b0;
  logic       pop_i       = 1'b0;
  logic       full_o;
  logic       empty_o;
  logic [7:0] byte_out_o;
  logic       is_data_o;
  logic       frame_end_o;

  // Shadow copy of the frame store and of the refresh pointer.
  logic [7:0]  shadow_store [STORE_BYTES];
  int unsigned stream_pos = 0;
  result_t     pending_bytes [$];

  bit          no_idle       = 1'b0;
  int unsigned fail_count    = 0;
  int unsigned items_sent    = 0;
  int unsigned bytes_checked = 0;
  int unsigned frames_seen   = 0;

  page_framebuffer_plotter #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .full_o     (full_o),
    .command_i  (command_i),
    .x_pos_i    (x_pos_i),
    .y_pos_i    (y_pos_i),
    .fill_i     (fill_i),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .byte_out_o (byte_out_o),
    .is_data_o  (is_data_o),
    .frame_end_o(frame_end_o)
  );

  // Free-running 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Applies one accepted item to the shadow state and queues the byte a refresh yields.
  function automatic void predict_item(logic [1:0] cmd, logic [7:0] x, logic [7:0] y,
                                       logic fill);
    int unsigned page;
    int unsigned slot;
    int unsigned idx;
    logic [7:0]  mask;
    result_t     r;
    case (cmd)
      CMD_PLOT: begin
        // The picture is stored upside down: row 0 lands in the last page, top bit.
        if (x < COLUMNS && y < ROWS) begin
          page = PAGES - 1 - y / 8;
          mask = 8'h80 >> (y % 8);
          idx  = x * PAGES + page;
          if (fill) begin
            shadow_store[idx] = shadow_store[idx] | mask;
          end else begin
            shadow_store[idx] = shadow_store[idx] & ~mask;
          end
        end
      end
      CMD_CLEAR: begin
        foreach (shadow_store[i]) shadow_store[i] = '0;
      end
      CMD_REFRESH: begin
        page = stream_pos / PAGE_SPAN;
        slot = stream_pos % PAGE_SPAN;
        r    = '0;
        if (slot == 0) begin
          r.byte_out = PAGE_CMD_BASE + 8'(page);
        end else if (slot == 1) begin
          r.byte_out = COL_LOW_CMD;
        end else if (slot == 2) begin
          r.byte_out = COL_HIGH_CMD;
        end else begin
          r.byte_out  = shadow_store[(slot - 3) * PAGES + page];
          r.is_data   = 1'b1;
          r.frame_end = (stream_pos == STREAM_LEN - 1);
        end
        stream_pos = (stream_pos == STREAM_LEN - 1) ? 0 : stream_pos + 1;
        pending_bytes.push_back(r);
      end
      default: begin
      end
    endcase
  endfunction

  // Compares each result transfer with the oldest predicted byte, then picks the next pop.
  always @(posedge clk_i) begin : result_checker
    result_t want;
    if (rst_ni && pop_i && !empty_o) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected result: byte_out %0h is_data %0b frame_end %0b",
               byte_out_o, is_data_o, frame_end_o);
        fail_count++;
      end else begin
        want = pending_bytes.pop_front();
        bytes_checked++;
        if (byte_out_o !== want.byte_out) begin
          $error("byte_out mismatch: expected %0h, actual %0h", want.byte_out, byte_out_o);
          fail_count++;
        end
        if (is_data_o !== want.is_data) begin
          $error("is_data mismatch: expected %0b, actual %0b", want.is_data, is_data_o);
          fail_count++;
        end
        if (frame_end_o !== want.frame_end) begin
          $error("frame_end mismatch: expected %0b, actual %0b", want.frame_end, frame_end_o);
          fail_count++;
        end
        if (want.frame_end) frames_seen++;
      end
    end
    pop_i <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // Offers one item, waits for its transfer and updates the prediction.
  task automatic send_item(logic [1:0] cmd, logic [7:0] x, logic [7:0] y, logic fill);
    if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      push_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    push_i    <= 1'b1;
    command_i <= cmd;
    x_pos_i   <= x;
    y_pos_i   <= y;
    fill_i    <= fill;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    predict_item(cmd, x, y, fill);
    items_sent++;
  endtask

  // Stops sending until every predicted byte has been popped.
  task automatic drain_results();
    push_i <= 1'b0;
    @(posedge clk_i);
    while (pending_bytes.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_refresh();
    send_item(CMD_REFRESH, 8'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // Mostly on-panel points, with some off the right or bottom edge.
  task automatic send_random_plot();
    logic [7:0] x;
    logic [7:0] y;
    x = 8'($urandom_range(COLUMNS - 1));
    y = 8'($urandom_range(ROWS - 1));
    case ($urandom_range(19))
      0:       x = 8'($urandom_range(255, COLUMNS));
      1:       y = 8'($urandom_range(255, ROWS));
      default: begin
      end
    endcase
    send_item(CMD_PLOT, x, y, 1'($urandom));
  endtask

  // Page 0 header right after reset.
  task automatic test_stream_header();
    repeat (3) send_refresh();
  endtask

  // Rows near the bottom land in page 0, so they show up in the first data bytes.
  task automatic test_plot_flip();
    send_item(CMD_PLOT, 8'd0, 8'd63, 1'b1);
    send_item(CMD_PLOT, 8'd1, 8'd56, 1'b1);
    send_item(CMD_PLOT, 8'd1, 8'd57, 1'b1);
    send_item(CMD_PLOT, 8'd1, 8'd57, 1'b0);
    send_refresh();
    send_refresh();
  endtask

  // Points just past and far past each edge are dropped; the valid corners are kept.
  task automatic test_off_panel();
    send_item(CMD_PLOT, 8'd128, 8'd63, 1'b1);
    send_item(CMD_PLOT, 8'd255, 8'd0, 1'b1);
    send_item(CMD_PLOT, 8'd2, 8'd64, 1'b1);
    send_item(CMD_PLOT, 8'd2, 8'd255, 1'b1);
    send_item(CMD_PLOT, 8'd255, 8'd255, 1'b1);
    send_item(CMD_PLOT, 8'd127, 8'd0, 1'b1);
    send_item(CMD_PLOT, 8'd0, 8'd0, 1'b1);
    send_refresh();
  endtask

  // The unused command code changes nothing and yields no byte.
  task automatic test_unused_command();
    send_item(CMD_UNUSED, 8'hFF, 8'hFF, 1'b1);
    send_refresh();
  endtask

  // A clear in the middle of a page zeroes the store but keeps the stream position.
  task automatic test_clear_mid_stream();
    send_item(CMD_PLOT, 8'd3, 8'd63, 1'b1);
    send_item(CMD_CLEAR, 8'hFF, 8'h00, 1'b1);
    send_refresh();
  endtask

  // Random mix with an idle-free stretch and one full drain in between.
  task automatic test_random_mix(int unsigned count);
    int unsigned pick;
    for (int unsigned n = 0; n < count; n++) begin
      no_idle = (n >= count / 4) && (n < count / 2);
      if (n == 2 * count / 3) drain_results();
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_random_plot();
      end else if (pick < 92) begin
        send_refresh();
      end else if (pick < 97) begin
        send_item(CMD_UNUSED, 8'($urandom), 8'($urandom), 1'($urandom));
      end else begin
        send_item(CMD_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom));
      end
    end
    no_idle = 1'b0;
  endtask

  // Mostly refresh ticks, so the stream runs through whole pages and their headers.
  task automatic test_page_sweep();
    int unsigned ticks;
    ticks = 0;
    while (ticks < 2 * PAGE_SPAN) begin
      if ($urandom_range(99) < 80) begin
        send_refresh();
        ticks++;
      end else begin
        send_random_plot();
      end
    end
  endtask

  initial begin : stimulus
    foreach (shadow_store[i]) shadow_store[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_stream_header();
    test_plot_flip();
    test_off_panel();
    test_unused_command();
    test_clear_mid_stream();
    test_random_mix(100);
    test_page_sweep();

    // Let any trailing clear or plot finish so a stray byte would still be caught.
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb: %0d items sent, %0d bytes checked, %0d complete frames streamed",
             items_sent, bytes_checked, frames_seen);
    $display("tb: covered plots on and off the panel, clears mid-stream, unused codes, pages");
    if (fail_count == 0 && pending_bytes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule
